// File: rtl/core/kct_pkg.sv
`default_nettype none

package kct_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int COORD_BITS_DEF    = 16;

    // Fixed field widths
    localparam int KEY_W     = 16;
    localparam int KIND_W    = 2;
    localparam int ADDR_W    = 48;
    localparam int COORD_IN_W = 16;
    localparam int SLOT_W    = 5;

    // Address kind codes
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADDR    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNDEF   = 2'd3;

    typedef enum logic [1:0] {
        ST_UNCHANGED = 2'd0,
        ST_UPDATED   = 2'd1,
        ST_INSERTED  = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
    } t_result;

    // Compare unit flags
    typedef struct packed {
        logic key_hit;
        logic coord_same;
    } t_match;

endpackage

`default_nettype wire

// File: rtl/core/kct_ram.sv
`default_nettype none

module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/kct_match.sv
`default_nettype none

// Shared compare unit: checks one stored entry against the held frame and
// builds the entry words for update and insert.
module kct_match
    import kct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int WORD_W     = KEY_W + KIND_W + ADDR_W + 3 * COORD_BITS
) (
    input  wire logic [WORD_W-1:0]       i_rdata,
    input  wire logic [KEY_W-1:0]        i_key,
    input  wire logic [KIND_W-1:0]       i_kind,
    input  wire logic [ADDR_W-1:0]       i_addr,
    input  wire logic [3*COORD_BITS-1:0] i_coord,
    output t_match                       o_match,
    output logic      [WORD_W-1:0]       o_upd_word,
    output logic      [WORD_W-1:0]       o_new_word
);

    localparam int KIND_LO  = KEY_W;
    localparam int ADDR_LO  = KEY_W + KIND_W;
    localparam int COORD_LO = KEY_W + KIND_W + ADDR_W;

    logic [KEY_W-1:0]        st_key;
    logic [KIND_W-1:0]       st_kind;
    logic [ADDR_W-1:0]       st_addr;
    logic [3*COORD_BITS-1:0] st_coord;
    logic                    has_addr;

    assign st_key   = i_rdata[KEY_W-1:0];
    assign st_kind  = i_rdata[KIND_LO +: KIND_W];
    assign st_addr  = i_rdata[ADDR_LO +: ADDR_W];
    assign st_coord = i_rdata[COORD_LO +: 3*COORD_BITS];

    assign has_addr = (i_kind != KIND_NONE);

    always_comb begin
        o_match.key_hit    = (st_key == i_key);
        o_match.coord_same = (st_coord == i_coord);
    end

    // Update keeps key; address and kind only replaced when the frame's kind is not KIND_NONE
    assign o_upd_word = {i_coord,
                         has_addr ? i_addr : st_addr,
                         has_addr ? i_kind : st_kind,
                         st_key};

    assign o_new_word = {i_coord, i_addr, i_kind, i_key};

endmodule

`default_nettype wire

// File: rtl/core/keyed_coordinate_table.sv
`default_nettype none

// Keyed coordinate table: fully associative key/value store of node records.
//
// Input channel (s_axis): one transfer per frame. tdata carries key, device
// address and x/y/z coordinates; tuser carries the address kind.
// Output channel (m_axis): one transfer per frame with status and slot.
//
// Slots fill in order and are never freed, so a fill count marks the valid
// entries. Each frame scans the filled slots through one read port of the
// entry RAM and one shared comparator, one slot per cycle, stopping at the
// first key hit; a miss ends in an insert at the fill count, or in a full
// status with the frame dropped when no slot is left.
// One frame at a time: s_axis_tready is high only while idle, so the next
// frame is taken only after the result of the last one is posted.
// Reset clears the fill count and the sequencer; no RAM clearing pass.
// A stalled receiver holds the result in the output register; the next frame
// is still accepted and scanned, and waits only to post its own result.
module keyed_coordinate_table
    import kct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] entry_key, [63:16] node_address, [79:64] coord_x,
    // [95:80] coord_y, [111:96] coord_z
    input  wire logic [111:0] s_axis_tdata,
    // [1:0] address_kind
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] status, [6:2] slot_index, [7] zero
    output logic [7:0]        m_axis_tdata
);

    localparam int IW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW     = $clog2(TABLE_ENTRIES + 1);
    localparam int CW3    = 3 * COORD_BITS;
    localparam int WORD_W = KEY_W + KIND_W + ADDR_W + CW3;

    // Sequencer and control
    t_state          r_state, n_state;
    logic [FW-1:0]   r_fill, n_fill;
    logic [FW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_cmp_idx, n_cmp_idx;
    logic            r_pend, n_pend;
    t_result         r_res, n_res;
    t_result         r_out;
    logic            r_out_valid, n_out_valid;
    logic            load_out;

    // Held frame
    logic [KEY_W-1:0]  r_key;
    logic [KIND_W-1:0] r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [CW3-1:0]    r_coord;

    // RAM and compare unit
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    t_match            m;
    logic [WORD_W-1:0] upd_word, new_word;

    // Scan control
    logic s_accept, hit, scan_end, issue, room;

    // Frame normalization
    logic [KIND_W-1:0]  in_kind;
    logic signed [31:0] cx, cy, cz;

    // Slot number narrowed to the result field
    logic [IW+SLOT_W-1:0] cmp_wide, fill_wide;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_kind = (s_axis_tuser == KIND_UNDEF) ? KIND_NONE : s_axis_tuser;
    assign cx = 32'(signed'(s_axis_tdata[79:64]));
    assign cy = 32'(signed'(s_axis_tdata[95:80]));
    assign cz = 32'(signed'(s_axis_tdata[111:96]));

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key   <= s_axis_tdata[15:0];
            r_kind  <= in_kind;
            r_addr  <= (in_kind == KIND_ADDR) ? s_axis_tdata[63:16] : '0;
            r_coord <= {cz[COORD_BITS-1:0], cy[COORD_BITS-1:0], cx[COORD_BITS-1:0]};
        end
    end

    kct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    kct_match #(
        .COORD_BITS (COORD_BITS),
        .WORD_W     (WORD_W)
    ) u_match (
        .i_rdata    (ram_rdata),
        .i_key      (r_key),
        .i_kind     (r_kind),
        .i_addr     (r_addr),
        .i_coord    (r_coord),
        .o_match    (m),
        .o_upd_word (upd_word),
        .o_new_word (new_word)
    );

    // Hit on the entry read last cycle; end when nothing left to compare
    assign hit      = (r_state == S_SCAN) && r_pend && m.key_hit;
    assign scan_end = (r_state == S_SCAN) && !hit && (r_idx >= r_fill);
    assign issue    = (r_state == S_SCAN) && !hit && (r_idx < r_fill);
    assign room     = (r_fill < FW'(TABLE_ENTRIES));
    assign load_out = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    assign cmp_wide  = {{SLOT_W{1'b0}}, r_cmp_idx};
    assign fill_wide = {{SLOT_W{1'b0}}, r_fill[IW-1:0]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and table writes
    always_comb begin
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_pend      = 1'b0;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_cmp_idx;
        ram_wdata   = upd_word;
        n_out_valid = r_out_valid;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
            end
            S_SCAN: begin
                n_pend    = issue;
                n_cmp_idx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + FW'(1);
                end
                if (hit) begin
                    n_res.slot   = cmp_wide[SLOT_W-1:0];
                    n_res.status = m.coord_same ? ST_UNCHANGED : ST_UPDATED;
                    ram_we       = !m.coord_same;
                end else if (scan_end) begin
                    if (room) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_fill[IW-1:0];
                        ram_wdata    = new_word;
                        n_fill       = r_fill + FW'(1);
                        n_res.status = ST_INSERTED;
                        n_res.slot   = fill_wide[SLOT_W-1:0];
                    end else begin
                        n_res.status = ST_FULL;
                        n_res.slot   = '0;
                    end
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.slot, r_out.status};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_end && room) |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("insert did not advance fill count");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL)) |->
            (r_fill == FW'(TABLE_ENTRIES)))
        else $error("full status with free slots");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (FW'(r_cmp_idx) < r_fill))
        else $error("hit on slot outside filled range");

endmodule

`default_nettype wire

// File: tb/sv/keyed_coordinate_table_test.sv
`timescale 1ns / 1ps

module keyed_coordinate_table_test;
    import kct_pkg::*;

    localparam int NODE_SLOTS = TABLE_ENTRIES_DEF;

    // One node frame as it travels on the input stream
    typedef struct {
        logic [KEY_W-1:0]           key;
        logic [KIND_W-1:0]          kind;
        logic [ADDR_W-1:0]          addr;
        logic [2:0][COORD_IN_W-1:0] coord;   // [0] x, [1] y, [2] z
    } t_node_frame;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [15:0] entry_key, [63:16] node_address, [79:64] coord_x,
    // [95:80] coord_y, [111:96] coord_z
    logic [111:0] s_axis_tdata = '0;
    // [1:0] address_kind
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [1:0] status, [6:2] slot_index, [7] zero
    logic [7:0]   m_axis_tdata;

    // Shadow copy of the table. Slots fill in order and never free, so a fill
    // count tells which entries are valid. Addresses never reach the output,
    // so only keys and coordinates are kept.
    logic [KEY_W-1:0]           node_keys [NODE_SLOTS];
    logic [2:0][COORD_IN_W-1:0] node_coords [NODE_SLOTS];
    int                         table_fill = 0;

    t_result expected_results[$];
    int      mismatch_count = 0;

    // Idle knobs for both sides, and the receiver hold-off counter
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_left = 0;

    keyed_coordinate_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Slot holding a key, or -1 on a miss. Search runs in slot order.
    function automatic int find_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < table_fill; i++) begin
            if (node_keys[i] == key) return i;
        end
        return -1;
    endfunction

    // Table lookup/update for one frame; returns the status and slot the
    // block should post. Kind codes only steer the address, which is not
    // visible at the output, so they play no part here.
    function automatic t_result lookup_and_update(t_node_frame f);
        t_result r;
        int      hit;
        hit = find_slot(f.key);
        if (hit >= 0) begin
            if (node_coords[hit] == f.coord) begin
                r.status = ST_UNCHANGED;
            end else begin
                node_coords[hit] = f.coord;
                r.status = ST_UPDATED;
            end
            r.slot = hit[SLOT_W-1:0];
        end else if (table_fill < NODE_SLOTS) begin
            node_keys[table_fill]   = f.key;
            node_coords[table_fill] = f.coord;
            r.status = ST_INSERTED;
            r.slot   = table_fill[SLOT_W-1:0];
            table_fill++;
        end else begin
            // table full: frame dropped, slot reads zero
            r.status = ST_FULL;
            r.slot   = '0;
        end
        return r;
    endfunction

    // Mostly random, with the signed extremes showing up now and then
    function automatic logic [COORD_IN_W-1:0] random_coord();
        case ($urandom_range(19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random frame. new_key_pct sets how often a fresh key is tried; the rest
    // reuse a stored key, often with its stored coordinates so that
    // unchanged hits are common, or with one or all coordinates moved.
    function automatic t_node_frame random_frame(int new_key_pct);
        t_node_frame f;
        int          s;
        f.kind = 2'($urandom_range(3));
        f.addr = {16'($urandom), 32'($urandom)};
        for (int c = 0; c < 3; c++) f.coord[c] = random_coord();
        if (table_fill > 0 && $urandom_range(99) >= new_key_pct) begin
            s = $urandom_range(table_fill - 1);
            f.key = node_keys[s];
            case ($urandom_range(3))
                0, 1: f.coord = node_coords[s];
                2: begin
                    f.coord = node_coords[s];
                    f.coord[$urandom_range(2)] = random_coord();
                end
                default: ;
            endcase
        end else begin
            f.key = 16'($urandom);
        end
        return f;
    endfunction

    // Drive one frame and wait for its transfer. Called and returns at a
    // falling edge; tvalid stays high afterwards so back-to-back frames
    // need no extra assignment in the same step.
    task automatic send_frame(t_node_frame f);
        while (tx_idle_on && $urandom_range(99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {f.coord, f.addr, f.key};
        s_axis_tuser  <= f.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(lookup_and_update(f));
        @(negedge i_clk);
    endtask

    // Sender goes quiet until every result is back
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_directed(logic [KEY_W-1:0] key, logic [KIND_W-1:0] kind,
                                 logic [ADDR_W-1:0] addr, logic [15:0] x,
                                 logic [15:0] y, logic [15:0] z);
        t_node_frame f;
        f.key   = key;
        f.kind  = kind;
        f.addr  = addr;
        f.coord = {z, y, x};
        send_frame(f);
    endtask

    // Inserts with each address kind, key extremes and coordinate extremes
    task automatic test_insert_address_kinds();
        send_directed(16'h0000, KIND_NONE, '0, 16'h0000, 16'h0000, 16'h0000);
        send_directed(16'hFFFF, KIND_ADDR, '1, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_directed(16'h1234, KIND_UNKNOWN, 48'hA5A5_5A5A_0F0F, 16'h8000,
                      16'h7FFF, 16'h0001);
        send_directed(16'hABCD, KIND_UNDEF, 48'h0000_FFFF_0000, 16'hFFFF,
                      16'hFFFF, 16'h8000);
        send_directed(16'h8000, KIND_ADDR, 48'h8000_0000_0001, 16'h0001,
                      16'h0002, 16'h0003);
    endtask

    // Key hits: same coordinates leave the entry alone whatever the address
    // says; any single moved coordinate is an update.
    task automatic test_hit_update_rules();
        send_directed(16'hFFFF, KIND_NONE, '0, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_directed(16'hABCD, KIND_ADDR, '1, 16'hFFFF, 16'hFFFF, 16'h8000);
        send_directed(16'h0000, KIND_NONE, '0, 16'h0000, 16'h0000, 16'h0001);
        send_directed(16'h0000, KIND_ADDR, 48'h1234_5678_9ABC, 16'h8000,
                      16'h0000, 16'h0001);
        send_directed(16'h0000, KIND_UNKNOWN, '0, 16'h8000, 16'h7FFF, 16'h0001);
        send_directed(16'h1234, KIND_UNDEF, '1, 16'h8000, 16'h7FFF, 16'h0001);
        send_directed(16'h1234, KIND_ADDR, '1, 16'h8001, 16'h7FFF, 16'h0001);
        send_directed(16'h8000, KIND_UNKNOWN, '0, 16'h0001, 16'h0002, 16'h0003);
        // back-to-back hits on the last filled slot
        send_directed(16'h8000, KIND_NONE, '0, 16'hFFFF, 16'h0002, 16'h0003);
        send_directed(16'h8000, KIND_NONE, '0, 16'hFFFF, 16'h0002, 16'h0003);
    endtask

    task automatic test_random_traffic(int count, int new_key_pct);
        repeat (count) send_frame(random_frame(new_key_pct));
    endtask

    // Receiver holds off for a long stretch while frames keep coming: the
    // output register fills, the next scan finishes and waits, and the
    // input has to stall.
    task automatic test_output_backpressure();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        rx_hold_left = 400;
        @(negedge i_clk);
        test_random_traffic(8, 30);
    endtask

    // Sender pauses until the pipe is empty, then resumes
    task automatic test_pause_until_drained();
        wait_results_drained();
        test_random_traffic(100, 30);
    endtask

    // Receiver: random ready, or a counted hold-off when one is asked for
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_idle_on) begin
            m_axis_tready <= ($urandom_range(99) >= 24);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: status %0d slot %0d",
                       m_axis_tdata[1:0], m_axis_tdata[6:2]);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[1:0] != want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, m_axis_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[6:2] != want.slot) begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot, m_axis_tdata[6:2]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_insert_address_kinds();
        test_hit_update_rules();
        // fills the table, then keeps hitting it with full drops mixed in
        test_random_traffic(700, 35);

        // long stretch with no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(300, 20);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        test_output_backpressure();
        test_pause_until_drained();
        test_random_traffic(520, 30);

        // last results, then a quiet stretch to catch strays
        wait_results_drained();
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("keyed_coordinate_table: match");
        end else begin
            $display("keyed_coordinate_table: mismatch");
        end
        $finish;
    end

    // Watchdog, well above the slowest correct run
    initial begin
        #20_000_000;
        $display("keyed_coordinate_table: mismatch");
        $finish;
    end

endmodule
